// ===== src/adx_pkg.sv =====
// ----------------------------------------------------------------------------
// adx_pkg
// Shared types and constants of the adamax momentum update unit.
// ----------------------------------------------------------------------------
package adx_pkg;

  // field widths
  localparam int unsigned IndexW  = 8;
  localparam int unsigned DataW   = 32;
  localparam int unsigned BetaW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // divider shape: one overflow check stage plus one stage per quotient bit
  localparam int unsigned QuotW     = 32;
  localparam int unsigned NumW      = 65;
  localparam int unsigned DenW      = 40;
  localparam int unsigned DivStages = QuotW + 1;

  // lanes
  localparam int unsigned LaneX = 0;
  localparam int unsigned LaneZ = 1;

  // register reset values
  localparam logic [BetaW-1:0] BetaOneRst  = 16'd58982;
  localparam logic [BetaW-1:0] BetaTwoRst  = 16'd65470;
  localparam logic [DataW-1:0] StepSizeRst = 32'd16777;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_BETA_ONE  = 2'd0,
    REG_BETA_TWO  = 2'd1,
    REG_STEP_SIZE = 2'd2
  } adx_reg_e;

  // input transaction
  typedef struct packed {
    logic [IndexW-1:0]       entry_index;
    logic signed [DataW-1:0] grad_x;
    logic signed [DataW-1:0] grad_z;
    logic signed [DataW-1:0] pos_x;
    logic signed [DataW-1:0] pos_z;
  } adx_in_t;

  // output transaction
  typedef struct packed {
    logic [IndexW-1:0]       out_index;
    logic signed [DataW-1:0] new_pos_x;
    logic signed [DataW-1:0] new_pos_z;
  } adx_out_t;

  // one moment store entry, both lanes
  typedef struct packed {
    logic [1:0][DataW-1:0] m;
    logic [1:0][DataW-1:0] u;
  } adx_entry_t;

  // per lane control that rides along the divider
  typedef struct packed {
    logic                    neg;
    logic                    zero;
    logic signed [DataW-1:0] pos;
  } adx_lane_side_t;

  typedef struct packed {
    logic [IndexW-1:0]         index;
    adx_lane_side_t [1:0]      lane;
  } adx_div_side_t;

endpackage

// ===== src/adx_div.sv =====
// ----------------------------------------------------------------------------
// adx_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module adx_div (
  input  logic                                   clk_i,
  input  logic [adx_pkg::DivStages-1:0]          en_i,
  input  logic [1:0][adx_pkg::NumW-1:0]          num_i,
  input  logic [1:0][adx_pkg::DenW-1:0]          den_i,
  input  adx_pkg::adx_div_side_t                 side_i,
  output logic [1:0][adx_pkg::QuotW-1:0]         quo_o,
  output logic [1:0]                             ovf_o,
  output adx_pkg::adx_div_side_t                 side_o
);

  localparam int unsigned Last = adx_pkg::DivStages - 1;
  localparam int unsigned WideW = adx_pkg::DenW + adx_pkg::QuotW;

  logic [adx_pkg::NumW-1:0]  rem_q  [adx_pkg::DivStages][2];
  logic [adx_pkg::DenW-1:0]  den_q  [adx_pkg::DivStages][2];
  logic [adx_pkg::QuotW-1:0] quo_q  [adx_pkg::DivStages][2];
  logic                      ovf_q  [adx_pkg::DivStages][2];
  adx_pkg::adx_div_side_t    side_q [adx_pkg::DivStages];

  // first stage: quotient too large for 32 bits when num / 2^32 >= den
  for (genvar l = 0; l < 2; l++) begin : g_head
    always_ff @(posedge clk_i) begin
      if (en_i[0]) begin
        rem_q[0][l] <= num_i[l];
        den_q[0][l] <= den_i[l];
        quo_q[0][l] <= '0;
        ovf_q[0][l] <= {7'd0, num_i[l][adx_pkg::NumW-1:adx_pkg::QuotW]} >= den_i[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      side_q[0] <= side_i;
    end
  end

  // bit stages, most significant quotient bit first
  for (genvar s = 1; s <= Last; s++) begin : g_stage
    localparam int unsigned Bit = Last - s;
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [WideW-1:0] sub_w;
      logic             ge_w;

      assign sub_w = {{adx_pkg::QuotW{1'b0}}, den_q[s-1][l]} << Bit;
      assign ge_w  = {{(WideW - adx_pkg::NumW){1'b0}}, rem_q[s-1][l]} >= sub_w;

      always_ff @(posedge clk_i) begin
        if (en_i[s]) begin
          quo_q[s][l] <= quo_q[s-1][l] | (adx_pkg::QuotW'(ge_w) << Bit);
          ovf_q[s][l] <= ovf_q[s-1][l];
        end
      end

      // remainder and divisor are not needed after the last bit
      if (s < Last) begin : g_keep
        always_ff @(posedge clk_i) begin
          if (en_i[s]) begin
            rem_q[s][l] <= ge_w ? rem_q[s-1][l] - sub_w[adx_pkg::NumW-1:0] : rem_q[s-1][l];
            den_q[s][l] <= den_q[s-1][l];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // results
  for (genvar l = 0; l < 2; l++) begin : g_out
    assign quo_o[l] = quo_q[Last][l];
    assign ovf_o[l] = ovf_q[Last][l];
  end
  assign side_o = side_q[Last];

endmodule

// ===== src/adamax_momentum_update_unit.sv =====
// ----------------------------------------------------------------------------
// adamax_momentum_update_unit
// Adamax style position update with per entry first moment and peak stores.
// ----------------------------------------------------------------------------
// The unit takes one point per clock while no moment hazard or stalled
// output holds it off, and returns the updated positions in order. Most
// of its pipeline is the 33 stage restoring divider that forms step*m/u (an
// overflow check and one stage per quotient bit); six further stages hold the
// store read, the products, the moments, the numerator, the divider inputs
// and the output clamp. Moments are read when a point is accepted and written
// back two stages later, so a point whose entry matches one of the two points
// accepted just before it is held off until that write-back is done.
// The moment stores come out of reset cleared through per entry valid flags,
// with no clearing pass.
module adamax_momentum_update_unit #(
  parameter int unsigned MOMENT_ENTRIES = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [adx_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [adx_pkg::DataW-1:0]       cfg_data_i,
  // points in
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  adx_pkg::adx_in_t                in_data_i,
  // positions out
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output adx_pkg::adx_out_t               out_data_o
);

  // only entries reachable by an 8 bit index are stored
  localparam int unsigned Depth = (MOMENT_ENTRIES < 256) ? MOMENT_ENTRIES : 256;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  // stage positions
  localparam int unsigned StRead  = 0;
  localparam int unsigned StMul   = 1;
  localparam int unsigned StMom   = 2;
  localparam int unsigned StNum   = 3;
  localparam int unsigned StDivIn = 4;
  localparam int unsigned StDiv   = 5;
  localparam int unsigned StOut   = StDiv + adx_pkg::DivStages;
  localparam int unsigned NumSt   = StOut + 1;

  localparam int unsigned DW = adx_pkg::DataW;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [adx_pkg::BetaW-1:0] beta_one_q, beta_two_q;
  logic [DW-1:0]             step_size_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_one_q  <= adx_pkg::BetaOneRst;
      beta_two_q  <= adx_pkg::BetaTwoRst;
      step_size_q <= adx_pkg::StepSizeRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        adx_pkg::REG_BETA_ONE:  beta_one_q  <= cfg_data_i[adx_pkg::BetaW-1:0];
        adx_pkg::REG_BETA_TWO:  beta_two_q  <= cfg_data_i[adx_pkg::BetaW-1:0];
        adx_pkg::REG_STEP_SIZE: step_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage flow control
  // --------------------------------------------------------------------------
  logic [NumSt-1:0] v_q, v_d, ld, opn;
  logic             hazard;
  logic [IdxW-1:0]  idx_in;
  logic [IdxW-1:0]  rd_idx_q, mu_idx_q;

  always_comb begin
    opn[NumSt-1] = !v_q[NumSt-1] || out_ready_i;
    for (int k = NumSt - 2; k >= 0; k--) begin
      opn[k] = !v_q[k] || opn[k+1];
    end
  end

  // hold off a point whose entry is still being updated
  assign hazard     = (v_q[StRead] && rd_idx_q == idx_in) ||
                      (v_q[StMul] && mu_idx_q == idx_in);
  assign in_ready_o = opn[StRead] && !hazard;

  always_comb begin
    ld[StRead] = in_valid_i && in_ready_o;
    for (int k = 1; k < NumSt; k++) begin
      ld[k] = opn[k] && v_q[k-1];
    end
    for (int k = 0; k < NumSt - 1; k++) begin
      v_d[k] = ld[k] || (v_q[k] && !ld[k+1]);
    end
    v_d[NumSt-1] = ld[NumSt-1] || (v_q[NumSt-1] && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // --------------------------------------------------------------------------
  // index wrap table
  // --------------------------------------------------------------------------
  logic [IdxW-1:0] mod_tbl [256];

  for (genvar k = 0; k < 256; k++) begin : g_mod
    assign mod_tbl[k] = IdxW'(k % MOMENT_ENTRIES);
  end

  assign idx_in = mod_tbl[in_data_i.entry_index];

  // --------------------------------------------------------------------------
  // moment store with per entry valid flags
  // --------------------------------------------------------------------------
  adx_pkg::adx_entry_t mem_q [Depth];
  adx_pkg::adx_entry_t rd_q, wr_w;
  logic [Depth-1:0]    vld_q;
  logic                rd_vld_q;
  adx_pkg::adx_in_t    rd_in_q;

  always_ff @(posedge clk_i) begin
    if (ld[StMom]) begin
      mem_q[mu_idx_q] <= wr_w;
    end
    if (ld[StRead]) begin
      rd_q     <= mem_q[idx_in];
      rd_vld_q <= vld_q[idx_in];
      rd_idx_q <= idx_in;
      rd_in_q  <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ld[StMom]) begin
      vld_q[mu_idx_q] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // multiply stage: decay and gradient products
  // --------------------------------------------------------------------------
  logic signed [48:0]          pm_d [2], pm_q [2];
  logic signed [49:0]          pg_d [2], pg_q [2];
  logic [47:0]                 pu_d [2], pu_q [2];
  logic [DW-1:0]               ag_d [2], ag_q [2];
  logic signed [DW-1:0]        mu_pos_q [2];
  logic [adx_pkg::IndexW-1:0]  mu_index_q;
  logic [16:0]                 wgt_w;
  logic signed [DW-1:0]        grad_w [2];
  logic signed [DW-1:0]        pos_w [2];
  logic signed [DW-1:0]        m_old_w [2];
  logic [DW-1:0]               u_old_w [2];

  assign wgt_w = 17'h10000 - {1'b0, beta_one_q};

  always_comb begin
    grad_w[adx_pkg::LaneX] = rd_in_q.grad_x;
    grad_w[adx_pkg::LaneZ] = rd_in_q.grad_z;
    pos_w[adx_pkg::LaneX]  = rd_in_q.pos_x;
    pos_w[adx_pkg::LaneZ]  = rd_in_q.pos_z;
    for (int l = 0; l < 2; l++) begin
      m_old_w[l] = rd_vld_q ? $signed(rd_q.m[l]) : '0;
      u_old_w[l] = rd_vld_q ? rd_q.u[l] : '0;
      pm_d[l]    = $signed({1'b0, beta_one_q}) * m_old_w[l];
      pg_d[l]    = $signed({1'b0, wgt_w}) * grad_w[l];
      pu_d[l]    = beta_two_q * u_old_w[l];
      ag_d[l]    = grad_w[l][DW-1] ? (~grad_w[l] + 32'd1) : grad_w[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[StMul]) begin
      pm_q       <= pm_d;
      pg_q       <= pg_d;
      pu_q       <= pu_d;
      ag_q       <= ag_d;
      mu_pos_q   <= pos_w;
      mu_idx_q   <= rd_idx_q;
      mu_index_q <= rd_in_q.entry_index;
    end
  end

  // --------------------------------------------------------------------------
  // moment stage: new first moment and peak, written back to the store
  // --------------------------------------------------------------------------
  logic signed [50:0]          acc_w [2];
  logic [47:0]                 ud_w [2];
  logic [DW-1:0]               m_d [2], u_d [2], m_q [2], u_q [2];
  logic signed [DW-1:0]        mo_pos_q [2];
  logic [adx_pkg::IndexW-1:0]  mo_index_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      acc_w[l] = 51'(pm_q[l]) + 51'(pg_q[l]) + 51'sd32768;
      m_d[l]   = acc_w[l][47:16];
      ud_w[l]  = pu_q[l] + 48'd32768;
      u_d[l]   = (ud_w[l][47:16] > ag_q[l]) ? ud_w[l][47:16] : ag_q[l];
      wr_w.m[l] = m_d[l];
      wr_w.u[l] = u_d[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[StMom]) begin
      m_q        <= m_d;
      u_q        <= u_d;
      mo_pos_q   <= mu_pos_q;
      mo_index_q <= mu_index_q;
    end
  end

  // --------------------------------------------------------------------------
  // numerator stage: step times moment magnitude
  // --------------------------------------------------------------------------
  logic [63:0]                 num_d [2], num_q [2];
  logic [DW-1:0]               mag_w [2];
  logic [DW-1:0]               nm_u_q [2];
  adx_pkg::adx_div_side_t      nm_side_d, nm_side_q;

  always_comb begin
    nm_side_d.index = mo_index_q;
    for (int l = 0; l < 2; l++) begin
      mag_w[l] = m_q[l][DW-1] ? (~m_q[l] + 32'd1) : m_q[l];
      num_d[l] = 64'(step_size_q) * 64'(mag_w[l]);
      nm_side_d.lane[l].neg  = m_q[l][DW-1];
      nm_side_d.lane[l].zero = (u_q[l] == '0);
      nm_side_d.lane[l].pos  = mo_pos_q[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[StNum]) begin
      num_q     <= num_d;
      nm_u_q    <= u_q;
      nm_side_q <= nm_side_d;
    end
  end

  // --------------------------------------------------------------------------
  // divider input stage: rounding bias and divisor
  // --------------------------------------------------------------------------
  logic [1:0][adx_pkg::NumW-1:0] dv_num_d, dv_num_q;
  logic [1:0][adx_pkg::DenW-1:0] dv_den_d, dv_den_q;
  adx_pkg::adx_div_side_t        dv_side_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dv_num_d[l] = adx_pkg::NumW'(num_q[l]) + adx_pkg::NumW'({nm_u_q[l], 7'd0});
      dv_den_d[l] = {nm_u_q[l], 8'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[StDivIn]) begin
      dv_num_q  <= dv_num_d;
      dv_den_q  <= dv_den_d;
      dv_side_q <= nm_side_q;
    end
  end

  // --------------------------------------------------------------------------
  // divider
  // --------------------------------------------------------------------------
  logic [1:0][adx_pkg::QuotW-1:0] quo_w;
  logic [1:0]                     ovf_w;
  adx_pkg::adx_div_side_t         qs_w;

  adx_div u_div (
    .clk_i  (clk_i),
    .en_i   (ld[StDiv +: adx_pkg::DivStages]),
    .num_i  (dv_num_q),
    .den_i  (dv_den_q),
    .side_i (dv_side_q),
    .quo_o  (quo_w),
    .ovf_o  (ovf_w),
    .side_o (qs_w)
  );

  // --------------------------------------------------------------------------
  // output stage: clamp the step and the new position
  // --------------------------------------------------------------------------
  logic [DW-1:0]        qc_w [2];
  logic signed [33:0]   np_w [2];
  logic signed [DW-1:0] res_w [2];
  adx_pkg::adx_out_t    out_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (qs_w.lane[l].neg) begin
        qc_w[l] = (ovf_w[l] || quo_w[l] > 32'h8000_0000) ? 32'h8000_0000 : quo_w[l];
        np_w[l] = 34'(qs_w.lane[l].pos) + $signed({2'b00, qc_w[l]});
      end else begin
        qc_w[l] = (ovf_w[l] || quo_w[l][DW-1]) ? 32'h7FFF_FFFF : quo_w[l];
        np_w[l] = 34'(qs_w.lane[l].pos) - $signed({2'b00, qc_w[l]});
      end
      if (qs_w.lane[l].zero) begin
        res_w[l] = qs_w.lane[l].pos;
      end else if (np_w[l][33:31] == 3'b000 || np_w[l][33:31] == 3'b111) begin
        res_w[l] = np_w[l][DW-1:0];
      end else if (np_w[l][33]) begin
        res_w[l] = 32'sh8000_0000;
      end else begin
        res_w[l] = 32'sh7FFF_FFFF;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[StOut]) begin
      out_q.out_index <= qs_w.index;
      out_q.new_pos_x <= res_w[adx_pkg::LaneX];
      out_q.new_pos_z <= res_w[adx_pkg::LaneZ];
    end
  end

  assign out_valid_o = v_q[StOut];
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // write-back marks the entry as holding data
  a_wb_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld[StMom] |=> vld_q[$past(mu_idx_q)])
    else $error("moment entry not marked valid after write-back");

  // an accepted transaction lands in the read stage
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[StRead])
    else $error("accepted transaction lost at read stage");

  // a stalled multiply stage keeps its entry until write-back
  a_mul_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[StMul] && !ld[StMom] |=> v_q[StMul] && $stable(mu_idx_q))
    else $error("multiply stage dropped a pending write-back");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives points with random gaps into the adamax momentum update unit and
// compares every returned position against an in-bench moment store model.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned Entries = 256;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [adx_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [adx_pkg::DataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  adx_pkg::adx_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  adx_pkg::adx_out_t out_data_o;

  adamax_momentum_update_unit #(.MOMENT_ENTRIES(Entries)) dut (.*);

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [adx_pkg::BetaW-1:0] beta_one_q = adx_pkg::BetaOneRst;
  logic [adx_pkg::BetaW-1:0] beta_two_q = adx_pkg::BetaTwoRst;
  logic [adx_pkg::DataW-1:0] step_q = adx_pkg::StepSizeRst;
  logic signed [adx_pkg::DataW-1:0] moment_store [Entries][2];
  logic [adx_pkg::DataW-1:0] peak_store [Entries][2];
  adx_pkg::adx_out_t expected_pos_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned hold_cycles = 0;
  bit stall_en = 1'b1;

  // one lane of the momentum and position update
  function automatic logic signed [adx_pkg::DataW-1:0] update_lane(int idx, int ln,
      logic signed [adx_pkg::DataW-1:0] g, logic signed [adx_pkg::DataW-1:0] pos);
    longint acc, m, delta, np;
    logic [63:0] absg, ud, u, mag, dv, q;
    acc = longint'(beta_one_q) * longint'(moment_store[idx][ln])
        + longint'(65536 - int'(beta_one_q)) * longint'(g) + 32768;
    m = acc >>> 16;
    absg = (g < 0) ? 64'(-longint'(g)) : 64'(longint'(g));
    ud = (64'(beta_two_q) * 64'(peak_store[idx][ln]) + 64'd32768) >> 16;
    u = (ud > absg) ? ud : absg;
    moment_store[idx][ln] = m[31:0];
    peak_store[idx][ln] = u[31:0];
    delta = 0;
    if (u != 0) begin
      mag = (m < 0) ? 64'(-m) : 64'(m);
      dv = u << 8;
      q = (64'(step_q) * mag + (dv >> 1)) / dv;
      if (m < 0) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        delta = -longint'(q);
      end else begin
        if (q > 64'h7fff_ffff) q = 64'h7fff_ffff;
        delta = longint'(q);
      end
    end
    np = longint'(pos) - delta;
    if (np > 64'sh7fff_ffff) np = 64'sh7fff_ffff;
    if (np < -64'sh8000_0000) np = -64'sh8000_0000;
    return np[31:0];
  endfunction

  // send one config transaction
  task automatic write_reg(adx_pkg::adx_reg_e r, logic [adx_pkg::DataW-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (r)
      adx_pkg::REG_BETA_ONE:  beta_one_q = v[adx_pkg::BetaW-1:0];
      adx_pkg::REG_BETA_TWO:  beta_two_q = v[adx_pkg::BetaW-1:0];
      adx_pkg::REG_STEP_SIZE: step_q = v;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // send one point, predicting its result at acceptance
  task automatic send_point(adx_pkg::adx_in_t p);
    adx_pkg::adx_out_t e;
    int idx;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    idx = p.entry_index % Entries;
    e.out_index = p.entry_index;
    e.new_pos_x = update_lane(idx, adx_pkg::LaneX, p.grad_x, p.pos_x);
    e.new_pos_z = update_lane(idx, adx_pkg::LaneZ, p.grad_z, p.pos_z);
    expected_pos_q.push_back(e);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (expected_pos_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 8000)) - 4000);
      3: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom();
    endcase
  endfunction

  function automatic adx_pkg::adx_in_t rand_point(int lo, int hi);
    adx_pkg::adx_in_t p;
    p.entry_index = 8'($urandom_range(lo, hi));
    p.grad_x = rand_word();
    p.grad_z = rand_word();
    p.pos_x = rand_word();
    p.pos_z = rand_word();
    return p;
  endfunction

  // burst sender with random gaps
  task automatic send_random(int n, int lo, int hi);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && n > 0) begin
        send_point(rand_point(lo, hi));
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // directed: extremes and the zero peak pass-through
  task automatic test_directed();
    adx_pkg::adx_in_t p;
    p = '{entry_index: 8'd0, grad_x: 32'sd0, grad_z: 32'sd0,
          pos_x: 32'sh1234_5678, pos_z: -32'sd5};
    send_point(p);
    p = '{8'd255, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff};
    send_point(p);
    p = '{8'd255, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000};
    send_point(p);
    p = '{8'd1, 32'sh0001_0000, -32'sh0001_0000, 32'sd0, 32'sd0};
    send_point(p);
    send_point(p);
    p = '{8'd2, -32'sd1, 32'sd1, 32'sh7fff_ffff, 32'sh8000_0000};
    send_point(p);
    p = '{8'hff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
    send_point(p);
    drain();
  endtask

  // register extremes, including the widest step
  task automatic test_settings();
    write_reg(adx_pkg::REG_BETA_ONE, 32'd0);
    write_reg(adx_pkg::REG_BETA_TWO, 32'hffff_ffff);
    write_reg(adx_pkg::REG_STEP_SIZE, 32'hffff_ffff);
    send_random(200, 0, 255);
    drain();
    write_reg(adx_pkg::REG_BETA_ONE, 32'h0000_ffff);
    write_reg(adx_pkg::REG_BETA_TWO, 32'd0);
    write_reg(adx_pkg::REG_STEP_SIZE, 32'd0);
    send_random(150, 0, 15);
    drain();
    write_reg(adx_pkg::REG_BETA_ONE, $urandom());
    write_reg(adx_pkg::REG_BETA_TWO, $urandom());
    write_reg(adx_pkg::REG_STEP_SIZE, $urandom_range(1, 32'h0400_0000));
    send_random(250, 0, 3);
    drain();
  endtask

  // long receiver hold-off while points keep coming, few entries for hazards
  task automatic test_backpressure();
    hold_cycles = 400;
    send_random(150, 0, 1);
    drain();
  endtask

  task automatic test_random();
    write_reg(adx_pkg::REG_BETA_ONE, adx_pkg::BetaOneRst);
    write_reg(adx_pkg::REG_BETA_TWO, adx_pkg::BetaTwoRst);
    write_reg(adx_pkg::REG_STEP_SIZE, 32'h0100_0000);
    send_random(650, 0, 255);
    drain();
  endtask

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (stall_en) begin
      out_ready_i <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 300) == 0) stall_en <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 100) == 0) stall_en <= 1'b1;
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    adx_pkg::adx_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pos_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %h", out_data_o);
      end else begin
        e = expected_pos_q.pop_front();
        if (out_data_o !== e) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp idx %0d x %h z %h, got idx %0d x %h z %h",
                     e.out_index, e.new_pos_x, e.new_pos_z,
                     out_data_o.out_index, out_data_o.new_pos_x, out_data_o.new_pos_z);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < Entries; i++) begin
      moment_store[i] = '{0, 0};
      peak_store[i] = '{0, 0};
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_settings();
    test_backpressure();
    test_random();
    if (mismatch_cnt == 0 && expected_pos_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // timeout
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
